// File: hdl/mi3_pkg.sv
// Shared constants, cofactor index tables and lane flag type for the 3x3 inverse block.
// No dependencies; the files that use it refer to it by scoped names.
package mi3_pkg;

    localparam int NUM_ELEM  = 9;
    localparam int DET_TERMS = 3;

    typedef int unsigned t_idx_tab [NUM_ELEM];
    typedef int unsigned t_det_tab [DET_TERMS];

    // adj[k] = e[PA]*e[PB] - e[QA]*e[QB]; cofactor sign folded in by swapping terms
    localparam t_idx_tab PA = '{4, 7, 1, 6, 0, 3, 3, 6, 0};
    localparam t_idx_tab PB = '{8, 2, 5, 5, 8, 2, 7, 1, 4};
    localparam t_idx_tab QA = '{7, 1, 4, 3, 6, 0, 6, 0, 3};
    localparam t_idx_tab QB = '{5, 8, 2, 8, 2, 5, 4, 7, 1};

    // expansion along row 0 uses adj00, adj10, adj20
    localparam t_det_tab DET_ADJ = '{0, 3, 6};

    typedef struct packed {
        logic [NUM_ELEM-1:0] ovf;
        logic [NUM_ELEM-1:0] neg;
        logic                sing;
    } t_lane_flags;

endpackage

// File: hdl/mi3_mat_if.sv
// Input channel: one 3x3 matrix per transfer, valid/ready handshake.
// Depends on nothing.
interface mi3_mat_if #(parameter int DATA_WIDTH = 32);
    logic valid;
    logic ready;
    logic signed [DATA_WIDTH-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;

    modport source(output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22, input ready);
    modport sink(input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22, output ready);
endinterface

// File: hdl/mi3_res_if.sv
// Result channel: inverse, determinant and singular flag per transfer.
// Depends on nothing.
interface mi3_res_if #(parameter int DATA_WIDTH = 32);
    logic valid;
    logic ready;
    logic signed [DATA_WIDTH-1:0] b00, b01, b02, b10, b11, b12, b20, b21, b22;
    logic signed [DATA_WIDTH-1:0] det_value;
    logic singular;

    modport source(output valid, b00, b01, b02, b10, b11, b12, b20, b21, b22,
                   det_value, singular, input ready);
    modport sink(input valid, b00, b01, b02, b10, b11, b12, b20, b21, b22,
                 det_value, singular, output ready);
endinterface

// File: hdl/mi3_cofactor.sv
// Five-stage cofactor pipeline: 2x2 minors (adjugate) and exact determinant.
// Depends on mi3_pkg.
module mi3_cofactor #(
    parameter int DATA_WIDTH = 32,
    localparam int AW = 2 * DATA_WIDTH + 1,
    localparam int DW = 3 * DATA_WIDTH + 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_vld,
    input  logic signed [DATA_WIDTH-1:0] i_a [mi3_pkg::NUM_ELEM],
    output logic                         o_vld,
    output logic signed [AW-1:0]         o_adj [mi3_pkg::NUM_ELEM],
    output logic signed [DW-1:0]         o_det
);
    localparam int W  = DATA_WIDTH;
    localparam int NE = mi3_pkg::NUM_ELEM;
    localparam int NT = mi3_pkg::DET_TERMS;

    logic [4:0] r_vld;

    logic signed [2*W-1:0] r_p1 [NE];
    logic signed [2*W-1:0] r_p2 [NE];
    logic signed [W-1:0]   r_e1 [NT];
    logic signed [W-1:0]   r_e2 [NT];
    logic signed [AW-1:0]  r_adj2 [NE];
    logic signed [AW-1:0]  r_adj3 [NE];
    logic signed [AW-1:0]  r_adj4 [NE];
    logic signed [AW-1:0]  r_adj5 [NE];
    logic signed [2*W:0]   r_pl [NT];
    logic signed [2*W:0]   r_ph [NT];
    logic signed [DW-1:0]  r_t [NT];
    logic signed [DW-1:0]  r_det;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_vld};
        end
    end

    for (genvar k = 0; k < NE; k++) begin : g_minor
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_p1[k]   <= i_a[mi3_pkg::PA[k]] * i_a[mi3_pkg::PB[k]];
                r_p2[k]   <= i_a[mi3_pkg::QA[k]] * i_a[mi3_pkg::QB[k]];
                r_adj2[k] <= AW'(r_p1[k]) - AW'(r_p2[k]);
                r_adj3[k] <= r_adj2[k];
                r_adj4[k] <= r_adj3[k];
                r_adj5[k] <= r_adj4[k];
            end
        end
    end

    // adjugate entry split into unsigned low word and signed high part
    for (genvar j = 0; j < NT; j++) begin : g_det
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_e1[j] <= i_a[j];
                r_e2[j] <= r_e1[j];
                r_pl[j] <= r_e2[j] * $signed({1'b0, r_adj2[mi3_pkg::DET_ADJ[j]][W-1:0]});
                r_ph[j] <= r_e2[j] * $signed(r_adj2[mi3_pkg::DET_ADJ[j]][AW-1:W]);
                r_t[j]  <= (DW'(r_ph[j]) <<< W) + DW'(r_pl[j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_det <= r_t[0] + r_t[1] + r_t[2];
        end
    end

    assign o_vld = r_vld[4];
    assign o_adj = r_adj5;
    assign o_det = r_det;

endmodule

// File: hdl/mi3_div_step.sv
// One restoring-division stage for all nine lanes: one quotient bit per lane.
// Depends on mi3_pkg.
module mi3_div_step #(
    parameter int DATA_WIDTH = 32,
    parameter int RW         = 164,
    parameter int D2W        = 99,
    parameter int SHIFT      = 0,
    localparam int QW        = DATA_WIDTH + 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_vld,
    input  logic [RW-1:0]                i_rem [mi3_pkg::NUM_ELEM],
    input  logic [QW-1:0]                i_q [mi3_pkg::NUM_ELEM],
    input  logic [D2W-1:0]               i_d2,
    input  mi3_pkg::t_lane_flags         i_flags,
    input  logic signed [DATA_WIDTH-1:0] i_detv,
    output logic                         o_vld,
    output logic [RW-1:0]                o_rem [mi3_pkg::NUM_ELEM],
    output logic [QW-1:0]                o_q [mi3_pkg::NUM_ELEM],
    output logic [D2W-1:0]               o_d2,
    output mi3_pkg::t_lane_flags         o_flags,
    output logic signed [DATA_WIDTH-1:0] o_detv
);
    localparam int NE = mi3_pkg::NUM_ELEM;

    logic                         r_vld;
    logic [RW-1:0]                r_rem [NE];
    logic [QW-1:0]                r_q [NE];
    logic [D2W-1:0]               r_d2;
    mi3_pkg::t_lane_flags         r_flags;
    logic signed [DATA_WIDTH-1:0] r_detv;

    logic [RW-1:0] w_lim;
    logic [RW:0]   w_diff [NE];

    assign w_lim = RW'(i_d2) << SHIFT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    for (genvar k = 0; k < NE; k++) begin : g_lane
        assign w_diff[k] = {1'b0, i_rem[k]} - {1'b0, w_lim};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_diff[k][RW] ? i_rem[k] : w_diff[k][RW-1:0];
                r_q[k]   <= {i_q[k][QW-2:0], ~w_diff[k][RW]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d2    <= i_d2;
            r_flags <= i_flags;
            r_detv  <= i_detv;
        end
    end

    assign o_vld   = r_vld;
    assign o_rem   = r_rem;
    assign o_q     = r_q;
    assign o_d2    = r_d2;
    assign o_flags = r_flags;
    assign o_detv  = r_detv;

endmodule

// File: hdl/mi3_divider.sv
// Divider pipeline: magnitudes, rounding numerators, overflow check, then
// DATA_WIDTH+1 restoring steps. Also rounds and saturates the determinant.
// Depends on mi3_pkg and mi3_div_step.
module mi3_divider #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16,
    localparam int AW = 2 * DATA_WIDTH + 1,
    localparam int DW = 3 * DATA_WIDTH + 2,
    localparam int QW = DATA_WIDTH + 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_vld,
    input  logic signed [AW-1:0]         i_adj [mi3_pkg::NUM_ELEM],
    input  logic signed [DW-1:0]         i_det,
    output logic                         o_vld,
    output logic [QW-1:0]                o_q [mi3_pkg::NUM_ELEM],
    output mi3_pkg::t_lane_flags         o_flags,
    output logic signed [DATA_WIDTH-1:0] o_detv
);
    localparam int W    = DATA_WIDTH;
    localparam int NE   = mi3_pkg::NUM_ELEM;
    localparam int D2W  = DW + 1;
    localparam int RWA  = 2 * W + 2 * FRAC_BITS + 3;
    localparam int RWB  = D2W + W + 2;
    localparam int RW   = (RWA > RWB) ? RWA : RWB;
    localparam int RDW  = DW + 1;
    localparam logic [RDW-1:0] DPOS_MAX = (RDW'(1) << (W - 1)) - RDW'(1);

    // front stages
    logic                r_vld1, r_vld2;
    logic [AW-1:0]       r_m [NE];
    logic [NE-1:0]       r_mneg;
    logic [DW-1:0]       r_d;
    logic                r_dneg;
    logic                r_sing;

    logic [RW-1:0]       n_num [NE];
    logic [RW-1:0]       w_lim;
    logic [RDW-1:0]      n_dr;
    logic signed [W-1:0] n_detv;
    mi3_pkg::t_lane_flags n_flags;

    // division chain
    wire [RW-1:0]        w_rem [W+2][NE];
    wire [QW-1:0]        w_q [W+2][NE];
    wire [D2W-1:0]       w_d2 [W+2];
    wire mi3_pkg::t_lane_flags w_flags [W+2];
    wire signed [W-1:0]  w_detv [W+2];
    wire                 w_vld [W+2];

    logic [RW-1:0]       r_rem0 [NE];
    logic [D2W-1:0]      r_d2;
    mi3_pkg::t_lane_flags r_flags;
    logic signed [W-1:0] r_detv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    for (genvar k = 0; k < NE; k++) begin : g_mag
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m[k]    <= i_adj[k][AW-1] ? AW'(-i_adj[k]) : AW'(i_adj[k]);
                r_mneg[k] <= i_adj[k][AW-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d    <= i_det[DW-1] ? DW'(-i_det) : DW'(i_det);
            r_dneg <= i_det[DW-1];
            r_sing <= (i_det == '0);
        end
    end

    // numerator |M|*2^(2F+1) + |D| over 2|D| rounds half away from zero
    assign w_lim = RW'({r_d, 1'b0}) << (W + 1);

    always_comb begin
        for (int k = 0; k < NE; k++) begin
            n_num[k]         = (RW'(r_m[k]) << (2 * FRAC_BITS + 1)) + RW'(r_d);
            n_flags.ovf[k]   = (n_num[k] >= w_lim);
            n_flags.neg[k]   = r_mneg[k] ^ r_dneg;
        end
        n_flags.sing = r_sing;
        n_dr = (RDW'(r_d) + (RDW'(1) << (2 * FRAC_BITS - 1))) >> (2 * FRAC_BITS);
        if (r_dneg) begin
            n_detv = (n_dr > DPOS_MAX + RDW'(1)) ? {1'b1, {(W-1){1'b0}}}
                                                 : W'(RDW'(0) - n_dr);
        end else begin
            n_detv = (n_dr > DPOS_MAX) ? {1'b0, {(W-1){1'b1}}} : W'(n_dr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem0  <= n_num;
            r_d2    <= {r_d, 1'b0};
            r_flags <= n_flags;
            r_detv  <= n_detv;
        end
    end

    for (genvar k = 0; k < NE; k++) begin : g_head
        assign w_rem[0][k] = r_rem0[k];
        assign w_q[0][k]   = '0;
    end
    assign w_d2[0]    = r_d2;
    assign w_flags[0] = r_flags;
    assign w_detv[0]  = r_detv;
    assign w_vld[0]   = r_vld2;

    for (genvar s = 0; s <= W; s++) begin : g_step
        mi3_div_step #(
            .DATA_WIDTH(W),
            .RW        (RW),
            .D2W       (D2W),
            .SHIFT     (W - s)
        ) u_step (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (i_en),
            .i_vld  (w_vld[s]),
            .i_rem  (w_rem[s]),
            .i_q    (w_q[s]),
            .i_d2   (w_d2[s]),
            .i_flags(w_flags[s]),
            .i_detv (w_detv[s]),
            .o_vld  (w_vld[s+1]),
            .o_rem  (w_rem[s+1]),
            .o_q    (w_q[s+1]),
            .o_d2   (w_d2[s+1]),
            .o_flags(w_flags[s+1]),
            .o_detv (w_detv[s+1])
        );
    end

    assign o_vld   = w_vld[W+1];
    assign o_q     = w_q[W+1];
    assign o_flags = w_flags[W+1];
    assign o_detv  = w_detv[W+1];

endmodule

// File: hdl/mi3_skid.sv
// Two-entry output buffer: output register plus skid register, registered ready.
// Depends on nothing.
module mi3_skid #(
    parameter int PW = 321
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  logic [PW-1:0] i_data,
    output logic          o_ready,
    output logic          o_vld,
    output logic [PW-1:0] o_data,
    input  logic          i_ready
);
    logic          r_out_vld, n_out_vld;
    logic          r_skid_vld, n_skid_vld;
    logic [PW-1:0] r_out_data, n_out_data;
    logic [PW-1:0] r_skid_data, n_skid_data;
    logic          w_push;

    assign o_ready = ~r_skid_vld;
    assign w_push  = i_vld & ~r_skid_vld;

    always_comb begin
        n_out_vld   = r_out_vld;
        n_out_data  = r_out_data;
        n_skid_vld  = r_skid_vld;
        n_skid_data = r_skid_data;
        if (!r_out_vld || i_ready) begin
            if (r_skid_vld) begin
                n_out_vld  = 1'b1;
                n_out_data = r_skid_data;
                n_skid_vld = 1'b0;
            end else begin
                n_out_vld  = w_push;
                n_out_data = i_data;
            end
        end else if (w_push) begin
            n_skid_vld  = 1'b1;
            n_skid_data = i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign o_vld  = r_out_vld;
    assign o_data = r_out_data;

    a_skid_has_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid entry without output entry");

    a_skid_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_vld && !i_ready) |=> (r_skid_vld && $stable(r_skid_data)))
        else $error("skid entry lost while stalled");

    a_out_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_ready) |=> (r_out_vld && $stable(r_out_data)))
        else $error("output entry changed while stalled");

endmodule

// File: hdl/matrix3x3_inverse_determinant.sv
// 3x3 matrix inverse and determinant, signed fixed point, streaming.
// i_mat (sink) takes one matrix a00..a22 per transfer; o_res (source) gives
// the inverse b00..b22, det_value and singular per transfer, in order.
// Determinant is computed exactly (cofactor expansion along row 0); det_value
// is det / 2^(2*FRAC_BITS); each inverse entry is adjugate * 2^(2*FRAC_BITS) / det.
// Both get one rounding, halves away from zero, then saturation to DATA_WIDTH bits.
// A zero determinant gives singular = 1 and all other outputs zero.
// Path from input transfer to o_res.valid: 5 cofactor stages, 2 divider front
// stages, DATA_WIDTH + 1 restoring steps, then the output register.
// Throughput: one matrix per cycle unless stalled; the nine lanes share one det
// and each restoring step resolves one quotient bit per lane.
// Stall: the whole pipeline freezes while the skid register is occupied;
// i_mat.ready is registered and a stalled result is held, nothing is dropped.
// Reset (i_rst_n low, synchronous) empties the pipeline and the output buffer.
// Depends on mi3_pkg, mi3_mat_if, mi3_res_if, mi3_cofactor, mi3_divider, mi3_skid.
module matrix3x3_inverse_determinant #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mi3_mat_if.sink     i_mat,
    mi3_res_if.source   o_res
);
    localparam int W  = DATA_WIDTH;
    localparam int NE = mi3_pkg::NUM_ELEM;
    localparam int AW = 2 * W + 1;
    localparam int DW = 3 * W + 2;
    localparam int QW = W + 1;
    localparam int PW = 10 * W + 1;
    localparam logic [QW-1:0] QPOS_MAX = (QW'(1) << (W - 1)) - QW'(1);

    logic                 w_en;
    logic signed [W-1:0]  w_a [NE];
    logic                 w_cf_vld;
    logic signed [AW-1:0] w_adj [NE];
    logic signed [DW-1:0] w_det;
    logic                 w_dv_vld;
    logic [QW-1:0]        w_q [NE];
    mi3_pkg::t_lane_flags w_flags;
    logic signed [W-1:0]  w_detv;
    logic signed [W-1:0]  w_b [NE];
    logic [PW-1:0]        w_pay;
    logic [PW-1:0]        w_out;

    assign w_a[0] = i_mat.a00;
    assign w_a[1] = i_mat.a01;
    assign w_a[2] = i_mat.a02;
    assign w_a[3] = i_mat.a10;
    assign w_a[4] = i_mat.a11;
    assign w_a[5] = i_mat.a12;
    assign w_a[6] = i_mat.a20;
    assign w_a[7] = i_mat.a21;
    assign w_a[8] = i_mat.a22;

    assign i_mat.ready = w_en;

    mi3_cofactor #(.DATA_WIDTH(W)) u_cofactor (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (i_mat.valid),
        .i_a    (w_a),
        .o_vld  (w_cf_vld),
        .o_adj  (w_adj),
        .o_det  (w_det)
    );

    mi3_divider #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_divider (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (w_cf_vld),
        .i_adj  (w_adj),
        .i_det  (w_det),
        .o_vld  (w_dv_vld),
        .o_q    (w_q),
        .o_flags(w_flags),
        .o_detv (w_detv)
    );

    // sign, saturation and singular zeroing
    always_comb begin
        for (int k = 0; k < NE; k++) begin
            if (w_flags.sing) begin
                w_b[k] = '0;
            end else if (w_flags.neg[k]) begin
                w_b[k] = (w_flags.ovf[k] || w_q[k] > QPOS_MAX + QW'(1))
                       ? {1'b1, {(W-1){1'b0}}} : W'(QW'(0) - w_q[k]);
            end else begin
                w_b[k] = (w_flags.ovf[k] || w_q[k] > QPOS_MAX)
                       ? {1'b0, {(W-1){1'b1}}} : W'(w_q[k]);
            end
        end
        for (int k = 0; k < NE; k++) begin
            w_pay[k*W +: W] = w_b[k];
        end
        w_pay[NE*W +: W] = w_detv;
        w_pay[PW-1]      = w_flags.sing;
    end

    mi3_skid #(.PW(PW)) u_skid (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (w_dv_vld),
        .i_data (w_pay),
        .o_ready(w_en),
        .o_vld  (o_res.valid),
        .o_data (w_out),
        .i_ready(o_res.ready)
    );

    assign o_res.b00       = w_out[0*W +: W];
    assign o_res.b01       = w_out[1*W +: W];
    assign o_res.b02       = w_out[2*W +: W];
    assign o_res.b10       = w_out[3*W +: W];
    assign o_res.b11       = w_out[4*W +: W];
    assign o_res.b12       = w_out[5*W +: W];
    assign o_res.b20       = w_out[6*W +: W];
    assign o_res.b21       = w_out[7*W +: W];
    assign o_res.b22       = w_out[8*W +: W];
    assign o_res.det_value = w_out[NE*W +: W];
    assign o_res.singular  = w_out[PW-1];

    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.singular) |->
            (o_res.det_value == '0 && o_res.b00 == '0 && o_res.b11 == '0 && o_res.b22 == '0))
        else $error("singular result with nonzero outputs");

endmodule

// File: tb/sv/tb_top.sv
// Testbench for matrix3x3_inverse_determinant: directed table then random matrices,
// checked against table results or an exact wide-integer inverse/determinant predictor.
// Depends on mi3_pkg, mi3_mat_if, mi3_res_if and the block RTL.
`timescale 1ns / 100ps

module tb_top;

    localparam int DW = 32;
    localparam int FB = 16;
    localparam int N_RAND = 1700;
    localparam int LATENCY = DW + 9;
    localparam longint CYCLE_LIMIT = 400000;

    typedef logic signed [DW-1:0] t_elem;
    typedef t_elem t_mat [9];

    typedef struct {
        t_elem inv [9];
        t_elem det;
        logic  sing;
    } t_inv_result;

    typedef struct {
        t_elem m [9];
        logic  known;
        t_inv_result res;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;
    mi3_mat_if #(.DATA_WIDTH(DW)) mat_if ();
    mi3_res_if #(.DATA_WIDTH(DW)) res_if ();

    matrix3x3_inverse_determinant #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_mat  (mat_if.sink),
        .o_res  (res_if.source)
    );

    t_inv_result inverse_queue [$];
    int      fail_count = 0;
    longint  cycle_count = 0;
    bit      quiet_tail = 0;
    bit      hold_sink = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic t_elem sat_round(logic signed [255:0] q);
        if (q > 256'sd2147483647) return 32'sh7fffffff;
        if (q < -256'sd2147483648) return 32'sh80000000;
        return q[DW-1:0];
    endfunction

    // exact signed division, halves away from zero
    function automatic logic signed [255:0] div_round(logic signed [255:0] n,
                                                     logic signed [255:0] d);
        logic [255:0] an, ad, q;
        logic neg;
        neg = (n < 0) != (d < 0);
        an = (n < 0) ? -n : n;
        ad = (d < 0) ? -d : d;
        q = (2 * an + ad) / (2 * ad);
        return neg ? -$signed(q) : $signed(q);
    endfunction

    function automatic t_inv_result invert_matrix(t_mat m);
        logic signed [255:0] e [9];
        logic signed [255:0] adj [9];
        logic signed [255:0] det;
        t_inv_result r;
        for (int i = 0; i < 9; i++) e[i] = m[i];
        adj[0] = e[4]*e[8] - e[7]*e[5];
        adj[1] = e[7]*e[2] - e[1]*e[8];
        adj[2] = e[1]*e[5] - e[4]*e[2];
        adj[3] = e[6]*e[5] - e[3]*e[8];
        adj[4] = e[0]*e[8] - e[6]*e[2];
        adj[5] = e[3]*e[2] - e[0]*e[5];
        adj[6] = e[3]*e[7] - e[6]*e[4];
        adj[7] = e[6]*e[1] - e[0]*e[7];
        adj[8] = e[0]*e[4] - e[3]*e[1];
        det = e[0]*adj[0] + e[1]*adj[3] + e[2]*adj[6];
        r.sing = (det == 0);
        for (int i = 0; i < 9; i++)
            r.inv[i] = r.sing ? '0 : sat_round(div_round(adj[i] <<< (2*FB), det));
        r.det = r.sing ? '0 : sat_round(div_round(det, 256'sd1 <<< (2*FB)));
        return r;
    endfunction

    function automatic t_elem rand_elem();
        case ($urandom_range(0, 9))
            0: return 32'sh80000000;
            1: return 32'sh7fffffff;
            2: return '0;
            3: return 32'sh00010000;
            4: return -32'sh00010000;
            5, 6: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
            7: return $signed($urandom_range(0, 32'hffffff)) - 32'sh800000;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_mat rand_matrix();
        t_mat m;
        for (int i = 0; i < 9; i++) m[i] = rand_elem();
        if ($urandom_range(0, 7) == 0) begin
            // make singular: duplicate one row
            for (int c = 0; c < 3; c++) m[6+c] = m[3+c];
        end
        return m;
    endfunction

    task automatic send_matrix(t_mat m);
        mat_if.valid <= 1'b1;
        {mat_if.a00, mat_if.a01, mat_if.a02} <= {m[0], m[1], m[2]};
        {mat_if.a10, mat_if.a11, mat_if.a12} <= {m[3], m[4], m[5]};
        {mat_if.a20, mat_if.a21, mat_if.a22} <= {m[6], m[7], m[8]};
        do @(posedge i_clk); while (!mat_if.ready);
    endtask

    task automatic source_gap();
        int g;
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            g = $urandom_range(1, 13);
            mat_if.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    t_dir_row dir_rows [$];

    task automatic build_table();
        t_dir_row r;
        t_elem one, mx, mn;
        one = 32'sh00010000; mx = 32'sh7fffffff; mn = 32'sh80000000;
        r.known = 1;
        r.m = '{default: '0};
        r.res.inv = '{default: '0}; r.res.det = '0; r.res.sing = 1;
        dir_rows.push_back(r);
        r.m = '{one, 0, 0, 0, one, 0, 0, 0, one};
        r.res.inv = '{one, 0, 0, 0, one, 0, 0, 0, one}; r.res.det = one; r.res.sing = 0;
        dir_rows.push_back(r);
        r.m = '{default: mx};
        r.res.inv = '{default: '0}; r.res.det = '0; r.res.sing = 1;
        dir_rows.push_back(r);
        r.m = '{default: mn};
        dir_rows.push_back(r);
        r.known = 0;
        r.m = '{mx, 0, 0, 0, mx, 0, 0, 0, mx}; dir_rows.push_back(r);
        r.m = '{mn, 0, 0, 0, mn, 0, 0, 0, mn}; dir_rows.push_back(r);
        r.m = '{1, 0, 0, 0, 1, 0, 0, 0, 1}; dir_rows.push_back(r);
        r.m = '{-1, 0, 0, 0, 1, 0, 0, 0, 1}; dir_rows.push_back(r);
        r.m = '{0, one, 0, one, 0, 0, 0, 0, -one}; dir_rows.push_back(r);
        r.m = '{2*one, one, 0, one, 3*one, one, 0, one, 4*one}; dir_rows.push_back(r);
        r.m = '{3, 0, 0, 0, one, 0, 0, 0, one}; dir_rows.push_back(r);
        r.m = '{32'sh8000, 0, 0, 0, one, 0, 0, 0, one}; dir_rows.push_back(r);
        r.m = '{-32'sh18000, 0, 0, 0, one, 0, 0, 0, one}; dir_rows.push_back(r);
        r.m = '{mx, mn, 1, -1, mx, mn, mn, 1, mx}; dir_rows.push_back(r);
        r.m = '{mn, mx, mx, mx, mn, mx, mx, mx, mn}; dir_rows.push_back(r);
        r.m = '{32'shffffffff, 32'shaaaaaaaa, 32'sh55555555, 32'sh0f0f0f0f,
                32'shf0f0f0f0, 32'sh33333333, 32'shcccccccc, 32'sh01234567, 32'sh89abcdef};
        dir_rows.push_back(r);
    endtask

    initial begin
        t_mat m;
        i_rst_n = 1'b0;
        mat_if.valid = 1'b0;
        {mat_if.a00, mat_if.a01, mat_if.a02, mat_if.a10, mat_if.a11,
         mat_if.a12, mat_if.a20, mat_if.a21, mat_if.a22} = '0;
        build_table();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (dir_rows[k]) begin
            source_gap();
            inverse_queue.push_back(dir_rows[k].known ? dir_rows[k].res
                                                      : invert_matrix(dir_rows[k].m));
            send_matrix(dir_rows[k].m);
        end
        for (int k = 0; k < N_RAND; k++) begin
            if (k == N_RAND - 200) quiet_tail = 1;
            if (k == 300) hold_sink = 1;
            source_gap();
            m = rand_matrix();
            inverse_queue.push_back(invert_matrix(m));
            send_matrix(m);
        end
        mat_if.valid <= 1'b0;
        wait (inverse_queue.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // one long receiver hold-off so the pipeline fills and back-pressures, plus random gaps
    initial begin
        int gap;
        res_if.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            if (hold_sink) begin
                hold_sink = 0;
                res_if.ready <= 1'b0;
                repeat (300) @(posedge i_clk);
            end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
                gap = $urandom_range(1, 13);
                res_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end else begin
                res_if.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_inv_result exp_r;
        t_elem got [9];
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = '{res_if.b00, res_if.b01, res_if.b02, res_if.b10, res_if.b11,
                    res_if.b12, res_if.b20, res_if.b21, res_if.b22};
            if (inverse_queue.size() == 0) begin
                $display("%0t unexpected transfer det=%h", $time, res_if.det_value);
                fail_count++;
            end else begin
                exp_r = inverse_queue.pop_front();
                for (int i = 0; i < 9; i++)
                    if (got[i] !== exp_r.inv[i]) begin
                        $display("%0t b%0d%0d exp %h got %h", $time, i / 3, i % 3,
                                 exp_r.inv[i], got[i]);
                        fail_count++;
                    end
                if (res_if.det_value !== exp_r.det) begin
                    $display("%0t det exp %h got %h", $time, exp_r.det, res_if.det_value);
                    fail_count++;
                end
                if (res_if.singular !== exp_r.sing) begin
                    $display("%0t singular exp %b got %b", $time, exp_r.sing,
                             res_if.singular);
                    fail_count++;
                end
            end
        end
    end

endmodule
